// ===== hdl/assert_macros.svh =====
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication failed");
`define ASSERT_NEVER(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
		else $error("forbidden condition");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEVER(label, clk, rst_n, a)
`endif
`endif

// ===== hdl/ssdfb_pkg.sv =====
package ssdfb_pkg;

	typedef struct packed {
		logic [15:0] value;
		logic        show_separator;
	} item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_before;
		logic       stop_after;
		logic       last;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
	localparam logic [7:0] CMD_ADDR_ZERO = 8'hC0;
	localparam logic [7:0] SEP_BIT       = 8'h80;

	// 52429 / 2^19 approximates 1/10 exactly for all 16-bit values
	localparam logic [15:0] RECIP_TEN  = 16'd52429;
	localparam int          RECIP_SHIFT = 19;

	localparam int SLOT_CMD  = 0;
	localparam int SLOT_ADDR = 1;
	localparam int SEP_DIGIT = 2;

	function automatic logic [7:0] seg_pattern(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'h3f;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5b;
			4'd3: p = 8'h4f;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6d;
			4'd6: p = 8'h7d;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7f;
			4'd9: p = 8'h6f;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

// ===== hdl/seven_segment_decimal_frame_builder.sv =====
// Items go from the digit extractor via the queue to the back-end byte sequencer.
// That sequencer sets the item rate; it emits one byte per cycle unless result_ready
// stalls it. The extractor takes a new item as it pushes its finished digits.
// A two-entry queue decouples digit extraction from byte output.
// Reset (arst_n low) empties the queue, the output register and both sequencers.
`include "assert_macros.svh"

module seven_segment_decimal_frame_builder #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  ssdfb_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_ready,
	output ssdfb_pkg::result_t result
);

	logic                        push_valid;
	logic                        push_ready;
	logic [DIGIT_COUNT-1:0][7:0] push_data;
	logic                        pop_valid;
	logic                        pop_ready;
	logic [DIGIT_COUNT-1:0][7:0] pop_data;
	ssdfb_pkg::queue_status_t    qstat;

	ssdfb_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ssdfb_queue #(.WIDTH(8 * DIGIT_COUNT)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.status     (qstat)
	);

	ssdfb_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`ASSERT_NEVER(a_queue_status, clk, arst_n, qstat.full && qstat.empty)
	`ASSERT_IMPLIES(a_start_cmd, clk, arst_n, result_valid && result.start_before, result.data_byte == ssdfb_pkg::CMD_DATA_AUTO || result.data_byte == ssdfb_pkg::CMD_ADDR_ZERO)
	`ASSERT_IMPLIES(a_last_flags, clk, arst_n, result_valid && result.last, result.stop_after && !result.start_before)

endmodule

// ===== hdl/ssdfb_queue.sv =====
module ssdfb_queue #(
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push_valid,
	output logic                     push_ready,
	input  logic [WIDTH-1:0]         push_data,
	output logic                     pop_valid,
	input  logic                     pop_ready,
	output logic [WIDTH-1:0]         pop_data,
	output ssdfb_pkg::queue_status_t status
);

	logic [1:0][WIDTH-1:0] mem_q;
	logic                  wr_q;
	logic                  rd_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  pop;

	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign push_ready   = !status.full;
	assign pop_valid    = !status.empty;
	assign pop_data     = mem_q[rd_q];
	assign push         = push_valid && push_ready;
	assign pop          = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/ssdfb_front.sv =====
module ssdfb_front #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  ssdfb_pkg::item_t            item,
	output logic                        push_valid,
	input  logic                        push_ready,
	output logic [DIGIT_COUNT-1:0][7:0] push_data
);

	localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic                        busy_q;
	logic                        done_q;
	logic [PW-1:0]               cnt_q;
	logic [15:0]                 rem_q;
	logic                        sep_q;
	logic [DIGIT_COUNT-1:0][7:0] pats_q;

	logic [31:0] prod;
	logic [15:0] quo;
	logic [3:0]  digit;
	logic [7:0]  pat;
	logic        step;
	logic        take;
	logic        pushed;
	logic        last_digit;

	assign push_valid = done_q;
	assign push_data  = pats_q;
	assign pushed     = done_q && push_ready;
	assign item_ready = !busy_q || pushed;
	assign take       = item_valid && item_ready;
	assign step       = busy_q && !done_q;
	assign last_digit = (cnt_q == PW'(DIGIT_COUNT - 1));

	always_comb begin
		prod  = rem_q * ssdfb_pkg::RECIP_TEN;
		quo   = 16'(prod >> ssdfb_pkg::RECIP_SHIFT);
		digit = 4'(rem_q - (quo << 3) - (quo << 1));
		pat   = ssdfb_pkg::seg_pattern(digit);
		if ((DIGIT_COUNT > ssdfb_pkg::SEP_DIGIT) && sep_q &&
				(cnt_q == PW'(ssdfb_pkg::SEP_DIGIT))) begin
			pat = pat | ssdfb_pkg::SEP_BIT;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q <= item.value;
			sep_q <= item.show_separator;
		end else if (step) begin
			rem_q <= quo;
		end
		if (step) begin
			pats_q[cnt_q] <= pat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (pushed) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
			end else if (step) begin
				if (last_digit) begin
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + PW'(1);
				end
			end
		end
	end

endmodule

// ===== hdl/ssdfb_back.sv =====
module ssdfb_back #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  logic [DIGIT_COUNT-1:0][7:0] pop_data,
	output logic                        result_valid,
	input  logic                        result_ready,
	output ssdfb_pkg::result_t          result
);

	localparam int IW = $clog2(DIGIT_COUNT + 2);
	localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic                        active_q;
	logic [IW-1:0]               idx_q;
	logic [DIGIT_COUNT-1:0][7:0] rec_q;
	logic                        out_valid_q;
	ssdfb_pkg::result_t          out_q;

	logic               load;
	logic               last_idx;
	logic [IW-1:0]      pos;
	ssdfb_pkg::result_t nxt;

	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign load         = active_q && (!out_valid_q || result_ready);
	assign last_idx     = (idx_q == IW'(DIGIT_COUNT + 1));
	assign pop_ready    = !active_q || (load && last_idx);
	assign pos          = IW'(DIGIT_COUNT + 1) - idx_q;

	always_comb begin
		nxt.data_byte    = rec_q[pos[PW-1:0]];
		nxt.start_before = 1'b0;
		nxt.stop_after   = last_idx;
		nxt.last         = last_idx;
		if (idx_q == IW'(ssdfb_pkg::SLOT_CMD)) begin
			nxt.data_byte    = ssdfb_pkg::CMD_DATA_AUTO;
			nxt.start_before = 1'b1;
			nxt.stop_after   = 1'b1;
		end else if (idx_q == IW'(ssdfb_pkg::SLOT_ADDR)) begin
			nxt.data_byte    = ssdfb_pkg::CMD_ADDR_ZERO;
			nxt.start_before = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			rec_q <= pop_data;
		end
		if (load) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (load) begin
				if (last_idx) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
